// ===== rtl/link_reconnect_backoff_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Link reconnect backoff controller assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_BACKOFF_CONTROLLER_TOP_ASSERT_SVH
`define LINK_RECONNECT_BACKOFF_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LRBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Link reconnect backoff controller package
// Word types, configuration layout and event codes shared by the RTL.
// ----------------------------------------------------------------------------
package lrbc_pkg;

  localparam int ATT_W   = 6;
  localparam int CFG_W   = 32;
  localparam int NOW_W   = 48;
  localparam int EGEN_W  = 32;
  localparam int CNT_W   = 32;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_POLL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_DISCONNECTED = 3'd1,
    EV_RECONNECTED  = 3'd2,
    EV_RETRY_DUE    = 3'd3,
    EV_EXHAUSTED    = 3'd4,
    EV_STALLED      = 3'd5
  } ev_code_t;

  typedef enum logic [1:0] {
    CFG_ATTEMPT_CEIL    = 2'd0,
    CFG_INITIAL_BACKOFF = 2'd1,
    CFG_MAX_BACKOFF     = 2'd2,
    CFG_EPISODE_BUDGET  = 2'd3
  } cfg_idx_t;

  localparam logic [2:0] COND_CONNECTED    = 3'd0;
  localparam logic [2:0] COND_DISCONNECTED = 3'd1;
  localparam logic [2:0] COND_CLOSED       = 3'd3;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_WRONG_STATE = 1'b1;

  localparam logic LINK_EGRESS = 1'b1;

  localparam logic [ATT_W-1:0] ATT_ONE = 6'd1;

  localparam logic [ATT_W-1:0] RST_ATTEMPT_CEIL    = 6'd3;
  localparam logic [CFG_W-1:0] RST_INITIAL_BACKOFF = 32'd100;
  localparam logic [CFG_W-1:0] RST_MAX_BACKOFF     = 32'd2000;
  localparam logic [CFG_W-1:0] RST_EPISODE_BUDGET  = 32'd10000;

  typedef struct packed {
    logic [ATT_W-1:0] attempt_ceil;
    logic [CFG_W-1:0] initial_backoff;
    logic [CFG_W-1:0] max_backoff;
    logic [CFG_W-1:0] episode_budget;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              link_select;
    logic [EGEN_W-1:0] event_generation;
    logic [2:0]        link_condition;
    logic              stall_flag;
    logic [NOW_W-1:0]  now_time;
  } in_word_t;

  typedef struct packed {
    logic              status;
    logic [2:0]        event_code;
    logic [EGEN_W-1:0] current_generation;
    logic [ATT_W-1:0]  attempt_count;
    logic              pending_flag;
    logic              exhausted_flag;
    logic              ingest_up;
    logic              egress_up;
    logic [CNT_W-1:0]  stale_count;
    logic [CNT_W-1:0]  stall_count;
    logic [NOW_W-1:0]  retry_time;
    logic [NOW_W-1:0]  deadline_time;
  } out_word_t;

endpackage

// ===== rtl/lrbc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file holding the backoff and episode settings.
// ----------------------------------------------------------------------------
module lrbc_cfg_regs
  import lrbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ATTEMPT_CEIL:    cfg_nxt.attempt_ceil    = cfg_wdata[ATT_W-1:0];
        CFG_INITIAL_BACKOFF: cfg_nxt.initial_backoff = cfg_wdata;
        CFG_MAX_BACKOFF:     cfg_nxt.max_backoff     = cfg_wdata;
        CFG_EPISODE_BUDGET:  cfg_nxt.episode_budget  = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attempt_ceil    <= RST_ATTEMPT_CEIL;
      cfg_r.initial_backoff <= RST_INITIAL_BACKOFF;
      cfg_r.max_backoff     <= RST_MAX_BACKOFF;
      cfg_r.episode_budget  <= RST_EPISODE_BUDGET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lrbc_backoff.sv =====
// ----------------------------------------------------------------------------
// Backoff delay
// Initial delay doubled once per attempt after the first, capped at the max.
// ----------------------------------------------------------------------------
module lrbc_backoff
  import lrbc_pkg::*;
(
  input  logic [ATT_W-1:0] attempts,
  input  logic [CFG_W-1:0] initial_backoff,
  input  logic [CFG_W-1:0] max_backoff,
  output logic [CFG_W-1:0] delay
);

  logic [ATT_W-1:0]   shift_n;
  logic [2*CFG_W-1:0] shifted;
  logic               over;

  // The shifted delay is compared against the cap, so the result is min(init << n, max).
  always_comb begin
    shift_n = (attempts > ATT_ONE) ? attempts - ATT_ONE : '0;
    shifted = (2*CFG_W)'(initial_backoff) << shift_n[ATT_W-2:0];
    over    = (shift_n[ATT_W-1] && (initial_backoff != '0)) ||
              (shifted[2*CFG_W-1:CFG_W] != '0);
    delay   = (over || (shifted[CFG_W-1:0] > max_backoff)) ? max_backoff
                                                            : shifted[CFG_W-1:0];
  end

endmodule

// ===== rtl/lrbc_engine.sv =====
// ----------------------------------------------------------------------------
// Recovery engine
// Episode state registers and the single-pass step that updates them.
// ----------------------------------------------------------------------------
`include "link_reconnect_backoff_controller_top_assert.svh"

module lrbc_engine
  import lrbc_pkg::*;
#(
  parameter int TIME_BITS     = 48,
  parameter int GEN_BITS      = 32,
  parameter int ATTEMPT_LIMIT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_word_t  word,
  input  cfg_t      cfg,
  output out_word_t res
);

  localparam int                 TW1    = TIME_BITS + 1;
  localparam logic [63:0]        TMAX64 = {64{1'b1}} >> (64 - TIME_BITS);
  localparam logic [ATT_W-1:0]   LIMIT  = ATT_W'(ATTEMPT_LIMIT);

  logic [GEN_BITS-1:0]  gen_r,   gen_nxt;
  logic [ATT_W-1:0]     att_r,   att_nxt;
  logic                 pend_r,  pend_nxt;
  logic                 exh_r,   exh_nxt;
  logic                 iup_r,   iup_nxt;
  logic                 eup_r,   eup_nxt;
  logic [TIME_BITS-1:0] rt_r,    rt_nxt;
  logic [TIME_BITS-1:0] dl_r,    dl_nxt;
  logic [CNT_W-1:0]     stale_r, stale_nxt;
  logic [CNT_W-1:0]     stall_r, stall_nxt;

  logic [63:0]          now64;
  logic [TIME_BITS-1:0] now_t;
  logic [ATT_W-1:0]     cap;
  logic                 restart_go;
  logic [ATT_W-1:0]     att_eff;
  logic [TIME_BITS-1:0] dl_eff;
  logic [TW1-1:0]       dl_sum;
  logic [TIME_BITS-1:0] dl_restart;
  logic [CFG_W-1:0]     delay;
  logic [TW1-1:0]       rt_sum;
  logic [TIME_BITS-1:0] rt_sat;
  logic [TIME_BITS-1:0] rt_plan;
  logic                 plan_exh;
  logic                 stale;
  logic                 is_egress;
  logic                 status;
  ev_code_t             ev;
  ev_code_t             plan_ev;

  always_comb begin
    now64 = 64'(word.now_time);
    now_t = TIME_BITS'((now64 > TMAX64) ? TMAX64 : now64);
  end

  assign cap        = (cfg.attempt_ceil > LIMIT) ? LIMIT : cfg.attempt_ceil;
  assign restart_go = iup_r & eup_r & ~pend_r;

  // Saturating deadline for a fresh episode.
  assign dl_sum     = {1'b0, now_t} + TW1'(cfg.episode_budget);
  assign dl_restart = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  assign att_eff = restart_go ? ATT_ONE : att_r;
  assign dl_eff  = restart_go ? dl_restart : dl_r;

  lrbc_backoff u_backoff (
    .attempts        (att_eff),
    .initial_backoff (cfg.initial_backoff),
    .max_backoff     (cfg.max_backoff),
    .delay           (delay)
  );

  // Retry time: saturating now + delay, clipped to the deadline.
  assign rt_sum   = {1'b0, now_t} + TW1'(delay);
  assign rt_sat   = rt_sum[TIME_BITS] ? '1 : rt_sum[TIME_BITS-1:0];
  assign rt_plan  = (rt_sat > dl_eff) ? dl_eff : rt_sat;
  assign plan_exh = (att_eff >= cap) || (now_t >= dl_eff);
  assign plan_ev  = plan_exh ? EV_EXHAUSTED :
                    (att_eff == ATT_ONE) ? EV_DISCONNECTED : EV_NONE;

  assign stale     = 64'(word.event_generation) != 64'(gen_r);
  assign is_egress = word.link_select == LINK_EGRESS;

  always_comb begin
    gen_nxt   = gen_r;
    att_nxt   = att_r;
    pend_nxt  = pend_r;
    exh_nxt   = exh_r;
    iup_nxt   = iup_r;
    eup_nxt   = eup_r;
    rt_nxt    = rt_r;
    dl_nxt    = dl_r;
    stale_nxt = stale_r;
    stall_nxt = stall_r;
    status    = STATUS_OK;
    ev        = EV_NONE;

    unique case (req_t'(word.req_type))
      REQ_START: begin
        gen_nxt   = GEN_BITS'(1);
        att_nxt   = ATT_ONE;
        pend_nxt  = 1'b0;
        exh_nxt   = 1'b0;
        iup_nxt   = 1'b0;
        eup_nxt   = 1'b0;
        rt_nxt    = '0;
        dl_nxt    = dl_restart;
        stale_nxt = '0;
        stall_nxt = '0;
      end
      REQ_EVENT: begin
        if (stale) begin
          stale_nxt = stale_r + CNT_W'(1);
          status    = STATUS_WRONG_STATE;
        end else if (exh_r) begin
          status = STATUS_WRONG_STATE;
        end else if (is_egress && word.stall_flag) begin
          stall_nxt = stall_r + CNT_W'(1);
          if (restart_go) begin
            att_nxt = ATT_ONE;
            rt_nxt  = '0;
            dl_nxt  = dl_restart;
          end
          if (!pend_r) begin
            if (plan_exh) begin
              exh_nxt  = 1'b1;
              pend_nxt = 1'b0;
            end else begin
              pend_nxt = 1'b1;
              rt_nxt   = rt_plan;
            end
          end
          ev = EV_STALLED;
        end else if (word.link_condition == COND_CONNECTED) begin
          if (is_egress) begin
            eup_nxt = 1'b1;
          end else begin
            iup_nxt = 1'b1;
          end
          if (!(iup_r && eup_r) && (is_egress ? iup_r : eup_r)) begin
            pend_nxt = 1'b0;
            ev       = EV_RECONNECTED;
          end
        end else if (word.link_condition >= COND_DISCONNECTED &&
                     word.link_condition <= COND_CLOSED) begin
          if (restart_go) begin
            att_nxt = ATT_ONE;
            rt_nxt  = '0;
            dl_nxt  = dl_restart;
          end
          if (is_egress) begin
            eup_nxt = 1'b0;
          end else begin
            iup_nxt = 1'b0;
          end
          if (!pend_r) begin
            if (plan_exh) begin
              exh_nxt  = 1'b1;
              pend_nxt = 1'b0;
            end else begin
              pend_nxt = 1'b1;
              rt_nxt   = rt_plan;
            end
            ev = plan_ev;
          end
        end
      end
      REQ_POLL: begin
        // A pending retry rules out a restart, so plan_exh sees the live state.
        if (exh_r) begin
          status = STATUS_WRONG_STATE;
        end else if (pend_r && (now_t >= rt_r)) begin
          if (plan_exh) begin
            exh_nxt  = 1'b1;
            pend_nxt = 1'b0;
            ev       = EV_EXHAUSTED;
          end else begin
            pend_nxt = 1'b0;
            iup_nxt  = 1'b0;
            eup_nxt  = 1'b0;
            att_nxt  = att_r + ATT_ONE;
            gen_nxt  = gen_r + GEN_BITS'(1);
            ev       = EV_RETRY_DUE;
          end
        end
      end
      REQ_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r   <= '0;
      att_r   <= '0;
      pend_r  <= 1'b0;
      exh_r   <= 1'b0;
      iup_r   <= 1'b0;
      eup_r   <= 1'b0;
      rt_r    <= '0;
      dl_r    <= '0;
      stale_r <= '0;
      stall_r <= '0;
    end else if (step_en) begin
      gen_r   <= gen_nxt;
      att_r   <= att_nxt;
      pend_r  <= pend_nxt;
      exh_r   <= exh_nxt;
      iup_r   <= iup_nxt;
      eup_r   <= eup_nxt;
      rt_r    <= rt_nxt;
      dl_r    <= dl_nxt;
      stale_r <= stale_nxt;
      stall_r <= stall_nxt;
    end
  end

  always_comb begin
    res.status             = status;
    res.event_code         = ev;
    res.current_generation = EGEN_W'(gen_nxt);
    res.attempt_count      = att_nxt;
    res.pending_flag       = pend_nxt;
    res.exhausted_flag     = exh_nxt;
    res.ingest_up          = iup_nxt;
    res.egress_up          = eup_nxt;
    res.stale_count        = stale_nxt;
    res.stall_count        = stall_nxt;
    res.retry_time         = NOW_W'(rt_nxt);
    res.deadline_time      = NOW_W'(dl_nxt);
  end

  `LRBC_ASSERT_NOW(a_pend_exh_excl, exh_r, !pend_r, "retry pending while exhausted")
  `LRBC_ASSERT_NOW(a_att_limit, 1'b1, att_r <= LIMIT, "attempt count above limit")
  `LRBC_ASSERT_NOW(a_retry_in_episode, pend_r, rt_r <= dl_r, "retry scheduled past deadline")

endmodule

// ===== rtl/link_reconnect_backoff_controller_top.sv =====
// ----------------------------------------------------------------------------
// Link reconnect backoff controller, top level
// Path: an accepted word passes the request register, then the result register, to out_valid.
// Throughput: one word per cycle while out_ready is high; set by the single-pass episode state update.
// Reset: synchronous active-low rst_n clears state and loads register defaults.
// ----------------------------------------------------------------------------
`include "link_reconnect_backoff_controller_top_assert.svh"

module link_reconnect_backoff_controller_top
  import lrbc_pkg::*;
#(
  parameter int TIME_BITS     = 48,
  parameter int GEN_BITS      = 32,
  parameter int ATTEMPT_LIMIT = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  // request words
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  // result words
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  // register writes
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Two register stages: the request register feeds the step logic, and the
  // result register holds the step's word until the sink takes it. State in
  // the engine updates on the same edge the result is captured, so the next
  // request word in line always sees the updated episode state.

  cfg_t      cfg;
  logic      req_valid_r;
  in_word_t  req_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t step_res;
  logic      step_fire;

  lrbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance a request into the result register whenever that register is
  // empty or being drained this cycle.
  assign step_fire = req_valid_r && (!out_valid_r || out_ready);

  // Accept a new word while the request register is empty or moving on.
  assign in_ready = !req_valid_r || step_fire;

  lrbc_engine #(
    .TIME_BITS     (TIME_BITS),
    .GEN_BITS      (GEN_BITS),
    .ATTEMPT_LIMIT (ATTEMPT_LIMIT)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_fire),
    .word    (req_word_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Request register: valid cleared by reset, payload held without reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_word_r <= in_word;
    end
  end

  // Result register: load on a step, drop valid once taken with nothing new.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_word_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `LRBC_ASSERT_NEXT(a_step_shows, step_fire, out_valid_r, "stepped word not presented")
  `LRBC_ASSERT_NEXT(a_req_hold, req_valid_r && !step_fire,
                    req_valid_r && $stable(req_word_r), "waiting request word lost")
  `LRBC_ASSERT_NEXT(a_drain, out_valid_r && out_ready && !step_fire, !out_valid_r,
                    "taken result word repeated")

endmodule

// ===== verif/lrbc_episode_checker.sv =====
// ----------------------------------------------------------------------------
// Link reconnect backoff controller result checker
// Watches the request, result and register ports, runs a cycle-free model of
// the backoff episode on every accepted request word, and compares each result
// word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lrbc_episode_checker
  import lrbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               open_results,
  output logic [31:0]      live_generation
);

  localparam logic [NOW_W-1:0] TIME_TOP  = '1;
  localparam logic [ATT_W-1:0] ATT_LIMIT = 6'd32;

  // register copy
  logic [ATT_W-1:0] lim_attempts;
  logic [CFG_W-1:0] first_delay;
  logic [CFG_W-1:0] delay_cap;
  logic [CFG_W-1:0] budget;

  // episode state
  logic [31:0]      gen_q;
  logic [ATT_W-1:0] att_q;
  logic             pend_q;
  logic             exh_q;
  logic             ing_up;
  logic             egr_up;
  logic [NOW_W-1:0] retry_at;
  logic [NOW_W-1:0] deadline_at;
  logic [31:0]      stale_cnt;
  logic [31:0]      stall_cnt;

  out_word_t status_words[$];

  function automatic logic [NOW_W-1:0] sat_add(logic [NOW_W-1:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {17'd0, a} + {1'b0, b};
    return (s > {17'd0, TIME_TOP}) ? TIME_TOP : s[NOW_W-1:0];
  endfunction

  function automatic logic [ATT_W-1:0] attempt_cap();
    return (lim_attempts > ATT_LIMIT) ? ATT_LIMIT : lim_attempts;
  endfunction

  function automatic logic [63:0] retry_delay();
    logic [63:0]      d;
    logic [ATT_W-1:0] n;
    d = {32'd0, first_delay};
    n = (att_q > ATT_ONE) ? att_q - ATT_ONE : '0;
    while (n > 0 && d < {32'd0, delay_cap}) begin
      d = d << 1;
      n--;
    end
    return (d > {32'd0, delay_cap}) ? {32'd0, delay_cap} : d;
  endfunction

  function automatic void clear_episode();
    gen_q       = '0;
    att_q       = '0;
    pend_q      = 1'b0;
    exh_q       = 1'b0;
    ing_up      = 1'b0;
    egr_up      = 1'b0;
    retry_at    = '0;
    deadline_at = '0;
    stale_cnt   = '0;
    stall_cnt   = '0;
  endfunction

  // Schedule the next retry, or give up when attempts or time ran out.
  function automatic ev_code_t arm_retry(logic [NOW_W-1:0] now);
    logic first_try;
    first_try = (att_q == ATT_ONE);
    if (att_q >= attempt_cap() || now >= deadline_at) begin
      exh_q  = 1'b1;
      pend_q = 1'b0;
      return EV_EXHAUSTED;
    end
    pend_q   = 1'b1;
    retry_at = sat_add(now, retry_delay());
    if (retry_at > deadline_at) retry_at = deadline_at;
    return first_try ? EV_DISCONNECTED : EV_NONE;
  endfunction

  // Open a fresh episode when a healthy pair drops.
  function automatic void reopen_episode(logic [NOW_W-1:0] now);
    if (!pend_q && ing_up && egr_up) begin
      att_q       = ATT_ONE;
      retry_at    = '0;
      deadline_at = sat_add(now, {32'd0, budget});
    end
  endfunction

  function automatic out_word_t apply_request(in_word_t w);
    out_word_t        r;
    logic             was_up;
    logic [NOW_W-1:0] now;
    r            = '0;
    r.status     = STATUS_OK;
    r.event_code = EV_NONE;
    now          = w.now_time;
    case (req_t'(w.req_type))
      REQ_START: begin
        clear_episode();
        gen_q       = 32'd1;
        att_q       = ATT_ONE;
        deadline_at = sat_add(now, {32'd0, budget});
      end
      REQ_EVENT: begin
        if (w.event_generation != gen_q) begin
          stale_cnt++;
          r.status = STATUS_WRONG_STATE;
        end else if (exh_q) begin
          r.status = STATUS_WRONG_STATE;
        end else begin
          was_up = ing_up && egr_up;
          if (w.link_select == LINK_EGRESS && w.stall_flag) begin
            stall_cnt++;
            if (was_up) reopen_episode(now);
            if (!pend_q) void'(arm_retry(now));
            r.event_code = EV_STALLED;
          end else if (w.link_condition == COND_CONNECTED) begin
            if (w.link_select == LINK_EGRESS) egr_up = 1'b1;
            else ing_up = 1'b1;
            if (!was_up && ing_up && egr_up) begin
              pend_q       = 1'b0;
              r.event_code = EV_RECONNECTED;
            end
          end else if (w.link_condition >= COND_DISCONNECTED &&
                       w.link_condition <= COND_CLOSED) begin
            if (was_up) reopen_episode(now);
            if (w.link_select == LINK_EGRESS) egr_up = 1'b0;
            else ing_up = 1'b0;
            if (!pend_q) r.event_code = arm_retry(now);
          end
        end
      end
      REQ_POLL: begin
        if (exh_q) begin
          r.status = STATUS_WRONG_STATE;
        end else if (pend_q && now >= retry_at) begin
          if (now >= deadline_at || att_q >= attempt_cap()) begin
            exh_q        = 1'b1;
            pend_q       = 1'b0;
            r.event_code = EV_EXHAUSTED;
          end else begin
            pend_q       = 1'b0;
            ing_up       = 1'b0;
            egr_up       = 1'b0;
            att_q        = att_q + ATT_ONE;
            gen_q        = gen_q + 32'd1;
            r.event_code = EV_RETRY_DUE;
          end
        end
      end
      default: ;
    endcase
    r.current_generation = gen_q;
    r.attempt_count      = att_q;
    r.pending_flag       = pend_q;
    r.exhausted_flag     = exh_q;
    r.ingest_up          = ing_up;
    r.egress_up          = egr_up;
    r.stale_count        = stale_cnt;
    r.stall_count        = stall_cnt;
    r.retry_time         = retry_at;
    r.deadline_time      = deadline_at;
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      lim_attempts = RST_ATTEMPT_CEIL;
      first_delay  = RST_INITIAL_BACKOFF;
      delay_cap    = RST_MAX_BACKOFF;
      budget       = RST_EPISODE_BUDGET;
      clear_episode();
      status_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ATTEMPT_CEIL:    lim_attempts = cfg_wdata[ATT_W-1:0];
          CFG_INITIAL_BACKOFF: first_delay  = cfg_wdata;
          CFG_MAX_BACKOFF:     delay_cap    = cfg_wdata;
          CFG_EPISODE_BUDGET:  budget       = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) status_words.push_back(apply_request(in_word));
      if (out_valid && out_ready) begin
        if (status_words.size() == 0) begin
          $error("result word with no request waiting");
          mismatches++;
        end else begin
          want = status_words.pop_front();
          check_field("status", 64'(want.status), 64'(out_word.status));
          check_field("event_code", 64'(want.event_code), 64'(out_word.event_code));
          check_field("current_generation", 64'(want.current_generation),
                      64'(out_word.current_generation));
          check_field("attempt_count", 64'(want.attempt_count),
                      64'(out_word.attempt_count));
          check_field("pending_flag", 64'(want.pending_flag),
                      64'(out_word.pending_flag));
          check_field("exhausted_flag", 64'(want.exhausted_flag),
                      64'(out_word.exhausted_flag));
          check_field("ingest_up", 64'(want.ingest_up), 64'(out_word.ingest_up));
          check_field("egress_up", 64'(want.egress_up), 64'(out_word.egress_up));
          check_field("stale_count", 64'(want.stale_count), 64'(out_word.stale_count));
          check_field("stall_count", 64'(want.stall_count), 64'(out_word.stall_count));
          check_field("retry_time", 64'(want.retry_time), 64'(out_word.retry_time));
          check_field("deadline_time", 64'(want.deadline_time),
                      64'(out_word.deadline_time));
        end
      end
    end
    open_results    = status_words.size();
    live_generation = gen_q;
  end

endmodule

// ===== verif/tb_link_reconnect_backoff_controller_top.sv =====
// ----------------------------------------------------------------------------
// Link reconnect backoff controller testbench
// Drives request words and register writes into the controller, throttles the
// result side, and leaves prediction and comparison to the episode checker.
// A short directed sequence walks through every request type and several corner cases,
// then six register settings each get a burst of mostly well-formed random
// episodes.
// ----------------------------------------------------------------------------
module tb_link_reconnect_backoff_controller_top;
  import lrbc_pkg::*;

  localparam int          NUM_PHASES  = 6;
  localparam int          LONG_HOLD   = 64;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          CALM_TAIL   = 60;
  localparam logic        LINK_INGEST = 1'b0;
  localparam logic [2:0]  COND_FAILED = 3'd2;
  localparam logic [2:0]  COND_OTHER  = 3'd4;
  localparam logic [2:0]  COND_TOP    = 3'd7;

  // one register setting plus the shape of its random burst
  typedef struct {
    logic [ATT_W-1:0] attempts;
    logic [CFG_W-1:0] first_ms;
    logic [CFG_W-1:0] cap_ms;
    logic [CFG_W-1:0] budget_ms;
    logic [NOW_W-1:0] start_ms;
    logic [31:0]      step_ms;
    int               words;
    bit               idle;
  } phase_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_wr_en = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int               mismatches;
  int               open_results;
  logic [31:0]      live_generation;

  logic             in_taken      = 1'b0;
  bit               idling        = 1'b0;
  bit               long_hold_req = 1'b0;
  int               sink_hold     = 0;
  int               cycles        = 0;
  logic [NOW_W-1:0] clock_ms      = '0;
  phase_t           plan [NUM_PHASES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_reconnect_backoff_controller_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lrbc_episode_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .open_results    (open_results),
    .live_generation (live_generation)
  );

  // Flag a request handshake so the driver can see it at the next falling edge.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // Bail out if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("link_reconnect_backoff_controller_top regression: fail");
      $finish;
    end
  end

  // Result side: one long hold when asked, short random stalls while idling,
  // otherwise always ready.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      sink_hold     = LONG_HOLD - 1;
      out_ready    <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      sink_hold  = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_word_t req_word(req_t r, logic lnk, logic [31:0] gen,
                                        logic [2:0] cond, logic stl,
                                        logic [NOW_W-1:0] now);
    in_word_t w;
    w.req_type         = r;
    w.link_select      = lnk;
    w.event_generation = gen;
    w.link_condition   = cond;
    w.stall_flag       = stl;
    w.now_time         = now;
    return w;
  endfunction

  // Move the wall clock forward, pinning at the top of the time range.
  function automatic void advance_clock(logic [31:0] step);
    logic [NOW_W:0] t;
    t        = {1'b0, clock_ms} + (NOW_W+1)'($urandom_range(0, step));
    clock_ms = t[NOW_W] ? '1 : t[NOW_W-1:0];
  endfunction

  // Mostly well-formed traffic against the live generation, with some stale
  // events, unused request codes and fully random words mixed in.
  function automatic in_word_t pick_request();
    in_word_t    w;
    logic [95:0] raw;
    logic [31:0] gen;
    int          roll;
    roll = $urandom_range(0, 99);
    gen  = live_generation;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       gen = live_generation - 32'd1;
        1:       gen = live_generation + 32'd1;
        default: gen = $urandom();
      endcase
    end
    w = req_word(REQ_POLL, 1'($urandom_range(0, 1)), gen,
                 3'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                              : $urandom_range(4, 7)),
                 ($urandom_range(0, 4) == 0), clock_ms);
    if (roll < 6) begin
      raw = {$urandom(), $urandom(), $urandom()};
      w   = in_word_t'(raw[$bits(in_word_t)-1:0]);
    end else if (roll < 12) begin
      w.req_type = REQ_START;
    end else if (roll < 16) begin
      w.req_type = REQ_NONE;
    end else if (roll < 56) begin
      w.req_type = REQ_EVENT;
    end
    return w;
  endfunction

  // Drop valid for a short burst now and then.
  task automatic pause_in();
    int n;
    if (idling && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offer one request word and hold it until it is taken.
  task automatic send(in_word_t w);
    pause_in();
    in_word  <= w;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_taken);
  endtask

  // Write all four registers back to back; the block is idle here.
  task automatic load_registers(phase_t ph);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ATTEMPT_CEIL;
    cfg_wdata <= {{(CFG_W-ATT_W){1'b0}}, ph.attempts};
    @(negedge clk);
    cfg_index <= CFG_INITIAL_BACKOFF;
    cfg_wdata <= ph.first_ms;
    @(negedge clk);
    cfg_index <= CFG_MAX_BACKOFF;
    cfg_wdata <= ph.cap_ms;
    @(negedge clk);
    cfg_index <= CFG_EPISODE_BUDGET;
    cfg_wdata <= ph.budget_ms;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    plan[0] = '{6'd4, 32'd10, 32'd80, 32'd1000, 48'd5000, 32'd150, 65, 1'b1};
    plan[1] = '{6'd1, 32'd1, 32'd1, 32'd1, 48'h0000_8000_0000, 32'd3, 60, 1'b0};
    plan[2] = '{6'd32, 32'd1, '1, '1, 48'd100, 32'd600, 65, 1'b1};
    plan[3] = '{6'd63, '1, '1, '1, 48'hFFFF_C000_0000, 32'h8000_0000, 60, 1'b1};
    plan[4] = '{6'd0, 32'd0, 32'd5, 32'd50, 48'd0, 32'd20, 60, 1'b1};
    plan[5] = '{6'd6, 32'd3, 32'd40, 32'd300, 48'h1234_5678_9ABC, 32'd60, 90, 1'b1};

    repeat (6) @(negedge clk);
    rst_n  <= 1'b1;
    idling  = 1'b1;
    @(negedge clk);

    // Directed walk on the reset register values (3 attempts, 100, 2000, 10000).
    // Unused request code with every field at its top, then a poll with
    // nothing scheduled.
    send(req_word(REQ_NONE, LINK_EGRESS, '1, COND_TOP, 1'b1, '1));
    send(req_word(REQ_POLL, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd5));
    // Open an episode and bring both links up.
    send(req_word(REQ_START, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd1000));
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_CONNECTED, 1'b0, 48'd1010));
    send(req_word(REQ_EVENT, LINK_EGRESS, live_generation, COND_CONNECTED, 1'b0, 48'd1020));
    // Conditions past closed change nothing.
    send(req_word(REQ_EVENT, LINK_EGRESS, live_generation, COND_OTHER, 1'b0, 48'd1030));
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_TOP, 1'b0, 48'd1040));
    // Stale generation gets counted and rejected.
    send(req_word(REQ_EVENT, LINK_INGEST, '1, COND_DISCONNECTED, 1'b0, 48'd1050));
    // Drop ingest: restart the episode and schedule the first retry.
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_DISCONNECTED, 1'b0,
                  48'd1100));
    send(req_word(REQ_POLL, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd1150));
    send(req_word(REQ_POLL, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd1200));
    // Egress stall schedules with a doubled delay; an ingest stall flag is
    // ignored and the failed condition goes through as usual.
    send(req_word(REQ_EVENT, LINK_EGRESS, live_generation, COND_CONNECTED, 1'b1, 48'd1210));
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_FAILED, 1'b1, 48'd1220));
    send(req_word(REQ_POLL, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd1410));
    // Third attempt fails: out of attempts; then everything is refused.
    send(req_word(REQ_EVENT, LINK_EGRESS, live_generation, COND_CLOSED, 1'b0, 48'd1500));
    send(req_word(REQ_POLL, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd1600));
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_CONNECTED, 1'b0, 48'd1700));
    // Episode opened at the top of the time range: the deadline saturates and
    // a stall there runs straight into it.
    send(req_word(REQ_START, LINK_EGRESS, '1, COND_TOP, 1'b1, '1));
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_CONNECTED, 1'b0, '1));
    send(req_word(REQ_EVENT, LINK_EGRESS, live_generation, COND_CONNECTED, 1'b1, '1));
    // Episode at time zero that runs out on the deadline, then a stale event.
    send(req_word(REQ_START, LINK_INGEST, '0, COND_CONNECTED, 1'b0, '0));
    send(req_word(REQ_EVENT, LINK_INGEST, live_generation, COND_DISCONNECTED, 1'b0, '0));
    send(req_word(REQ_POLL, LINK_INGEST, '0, COND_CONNECTED, 1'b0, 48'd20000));
    send(req_word(REQ_EVENT, LINK_EGRESS, '0, COND_CONNECTED, 1'b0, '0));

    // Random bursts, one per register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      while (open_results != 0) @(negedge clk);
      load_registers(plan[p]);
      clock_ms = plan[p].start_ms;
      idling   = plan[p].idle;
      for (int i = 0; i < plan[p].words; i++) begin
        // calm finish: no stalls on either side
        if (p == NUM_PHASES - 1 && i == plan[p].words - CALM_TAIL) idling = 1'b0;
        // back up the result side while requests keep coming
        if (p == 0 && i == 20) long_hold_req = 1'b1;
        advance_clock(plan[p].step_ms);
        send(pick_request());
      end
    end

    // Drain and let any stray result show up.
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("link_reconnect_backoff_controller_top regression: pass");
    end else begin
      $display("link_reconnect_backoff_controller_top regression: fail");
    end
    $finish;
  end

endmodule
